[hdl/eprf_pkg.sv]
`timescale 1ns / 1ps

package eprf_pkg;

  // default build of the block
  localparam int TIMER_BITS_DEF = 24;
  localparam int WINDOW_DEF     = 5;

  // heights in 1/16 cm
  localparam int                HEIGHT_W   = 16;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  // configuration port
  localparam int                CFG_IDX_W      = 4;
  localparam int                CFG_DATA_W     = 16;
  localparam logic [CFG_DATA_W-1:0] LOW_LIMIT_RST  = 16'd16;
  localparam logic [CFG_DATA_W-1:0] HIGH_LIMIT_RST = 16'd4800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = CFG_IDX_W'(0),
    CFG_HIGH_LIMIT = CFG_IDX_W'(1)
  } cfg_reg_e;

  // height = floor(width * 17 / 7500), saturating at HEIGHT_MAX
  // widths at or above DIST_SAT_WIDTH saturate; below it width fits SCALE_IN_W bits
  localparam int SCALE_IN_W     = 25;
  localparam logic [SCALE_IN_W-1:0] DIST_SAT_WIDTH = 25'd28912942;
  localparam int SCALE_X_W      = 29;           // width * 17 below the saturation point
  localparam int SCALE_RECIP_W  = 30;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 30'd586406202; // ceil(2^42 / 7500)
  localparam int SCALE_SHIFT    = 42;

  // result channel packing
  localparam int OUT_FIELDS_W = 2 * HEIGHT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // per-stage control that travels with an item
  typedef struct packed {
    logic valid;
    logic done;   // item closed a pulse
  } stage_ctl_t;

endpackage

[hdl/eprf_dist.sv]
`timescale 1ns / 1ps

module eprf_dist #(
  parameter int TIMER_BITS = eprf_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [TIMER_BITS-1:0]         capture_i,
  output eprf_pkg::stage_ctl_t          ctl_o,
  output logic [eprf_pkg::HEIGHT_W-1:0] raw_o
);
  import eprf_pkg::*;

  localparam int CmpW  = (TIMER_BITS > SCALE_IN_W) ? TIMER_BITS : SCALE_IN_W;
  localparam int ProdW = SCALE_X_W + SCALE_RECIP_W;

  // edge pairing state
  logic                  awaiting_q, awaiting_d;
  logic [TIMER_BITS-1:0] start_q, start_d;

  // stage 1: pulse width
  stage_ctl_t            ctl1_q, ctl1_d;
  logic [TIMER_BITS-1:0] width_q, width_d;

  // stage 2: width * 17 and saturation flag
  stage_ctl_t            ctl2_q;
  logic [CmpW-1:0]       width_ext;
  logic [SCALE_X_W-1:0]  x_q, x_d;
  logic                  sat_q, sat_d;

  // stage 3: constant divide
  stage_ctl_t            ctl3_q;
  logic [ProdW-1:0]      prod;
  logic [HEIGHT_W-1:0]   raw_q, raw_d;

  always_comb begin
    awaiting_d = awaiting_q;
    start_d    = start_q;
    ctl1_d     = '{valid: in_valid_i, done: 1'b0};
    // wrap rule: end not after start counts through the top of the timer
    width_d    = capture_i - start_q - TIMER_BITS'(capture_i <= start_q);
    if (in_valid_i) begin
      if (!awaiting_q) begin
        start_d    = capture_i;
        awaiting_d = 1'b1;
      end else begin
        awaiting_d  = 1'b0;
        ctl1_d.done = 1'b1;
      end
    end
  end

  assign width_ext = CmpW'(width_q);
  assign sat_d     = (width_ext >= CmpW'(DIST_SAT_WIDTH));
  assign x_d       = SCALE_X_W'({width_ext[SCALE_IN_W-1:0], 4'b0000})
                   + SCALE_X_W'(width_ext[SCALE_IN_W-1:0]);

  assign prod  = ProdW'(x_q) * ProdW'(SCALE_RECIP);
  assign raw_d = sat_q ? HEIGHT_MAX : prod[SCALE_SHIFT +: HEIGHT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      start_q    <= '0;
      ctl1_q     <= '0;
      ctl2_q     <= '0;
      ctl3_q     <= '0;
    end else if (en_i) begin
      awaiting_q <= awaiting_d;
      start_q    <= start_d;
      ctl1_q     <= ctl1_d;
      ctl2_q     <= ctl1_q;
      ctl3_q     <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      width_q <= width_d;
      x_q     <= x_d;
      sat_q   <= sat_d;
      raw_q   <= raw_d;
    end
  end

  assign ctl_o = ctl3_q;
  assign raw_o = raw_q;

endmodule

[hdl/eprf_avg.sv]
`timescale 1ns / 1ps

module eprf_avg #(
  parameter int WINDOW = eprf_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  eprf_pkg::stage_ctl_t          ctl_i,
  input  logic [eprf_pkg::HEIGHT_W-1:0] raw_i,
  output eprf_pkg::stage_ctl_t          ctl_o,
  output logic [eprf_pkg::HEIGHT_W-1:0] raw_o,
  output logic [eprf_pkg::HEIGHT_W-1:0] avg_o
);
  import eprf_pkg::*;

  localparam int IdxW   = $clog2(WINDOW);
  localparam int SumW   = HEIGHT_W + IdxW;
  localparam int Shift  = SumW + IdxW;
  localparam int RecipW = SumW + 1;
  localparam longint Recip = ((64'd1 << Shift) + WINDOW - 1) / WINDOW;
  localparam int ProdW  = SumW + RecipW;

  logic                update;

  // stage 4: ring and running sum
  logic [HEIGHT_W-1:0] win_q [WINDOW];
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [HEIGHT_W-1:0] last_raw_q;
  stage_ctl_t          ctl4_q;
  logic [HEIGHT_W-1:0] raw4_q;
  logic [SumW-1:0]     sum4_q;

  // stage 5: mean
  logic [ProdW-1:0]    prod;
  logic [HEIGHT_W-1:0] mean;
  logic [HEIGHT_W-1:0] avg_q;
  stage_ctl_t          ctl5_q;
  logic [HEIGHT_W-1:0] raw5_q, avg5_q;

  assign update = en_i && ctl_i.valid && ctl_i.done;
  assign sum_d  = sum_q - SumW'(win_q[idx_q]) + SumW'(raw_i);
  assign idx_d  = (idx_q == IdxW'(WINDOW - 1)) ? '0 : idx_q + 1'b1;

  assign prod = ProdW'(sum4_q) * ProdW'(Recip);
  assign mean = prod[Shift +: HEIGHT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= '0;
      end
      idx_q      <= '0;
      sum_q      <= '0;
      last_raw_q <= '0;
      avg_q      <= '0;
      ctl4_q     <= '0;
      ctl5_q     <= '0;
    end else begin
      if (update) begin
        win_q[idx_q] <= raw_i;
        idx_q        <= idx_d;
        sum_q        <= sum_d;
        last_raw_q   <= raw_i;
      end
      if (en_i) begin
        ctl4_q <= ctl_i;
        ctl5_q <= ctl4_q;
        if (ctl4_q.valid && ctl4_q.done) begin
          avg_q <= mean;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw4_q <= ctl_i.done ? raw_i : last_raw_q;
      sum4_q <= sum_d;
      raw5_q <= raw4_q;
      avg5_q <= ctl4_q.done ? mean : avg_q;
    end
  end

  assign ctl_o = ctl5_q;
  assign raw_o = raw5_q;
  assign avg_o = avg5_q;

endmodule

[hdl/echo_pulse_range_filter_unit.sv]
`timescale 1ns / 1ps

// echo pulse range filter: every transfer on the input stream is one captured
// timer edge; edges alternate rising, falling. a rising edge stores its time,
// the following falling edge closes the pulse, turns its width (with timer
// wrap) into a distance in 1/16 cm, saturated at 65535, and pushes it into a
// WINDOW-entry ring whose truncated mean is the filtered height. each input
// transfer gives exactly one output transfer, in order, carrying the latest
// raw height, the filtered height, a flag telling whether this edge closed a
// pulse, and whether the filtered height lies above low_limit and at or
// below high_limit. one item is taken every clock while the pipeline is not
// held; the input transfer loads the input register, and the item then passes
// through three stages for width and constant divide and two stages for the
// ring sum and mean into the output register, from which its output transfer
// is made. the whole pipeline holds when the output register is full and not
// taken, so s_axis_tready follows the output side. limits are written over the
// cfg channel, which is always ready, and should only change while no item is
// in flight.
module echo_pulse_range_filter_unit #(
  parameter  int WINDOW     = eprf_pkg::WINDOW_DEF,
  parameter  int TIMER_BITS = eprf_pkg::TIMER_BITS_DEF,
  localparam int InTdataW   = ((TIMER_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [InTdataW-1:0]              s_axis_tdata_i,  // capture_time
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // raw_height, filtered_height, range_ok, zero fill
  output logic [eprf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tuser_o,  // measurement_done
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [eprf_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [eprf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import eprf_pkg::*;

  // pipeline advance: output register free or being drained
  logic                  en;

  // input register
  logic                  in_valid_q;
  logic [TIMER_BITS-1:0] cap_q;

  // limits
  logic [CFG_DATA_W-1:0] low_limit_q;
  logic [CFG_DATA_W-1:0] high_limit_q;

  // between the stages
  stage_ctl_t            ctl3;
  logic [HEIGHT_W-1:0]   raw3;
  stage_ctl_t            ctl5;
  logic [HEIGHT_W-1:0]   raw5;
  logic [HEIGHT_W-1:0]   avg5;
  logic                  range_ok_d;

  // output register
  logic                  out_valid_q;
  logic [HEIGHT_W-1:0]   out_raw_q;
  logic [HEIGHT_W-1:0]   out_avg_q;
  logic                  out_done_q;
  logic                  out_range_ok_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  // input register, upper capture bits beyond the timer are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cap_q <= s_axis_tdata_i[TIMER_BITS-1:0];
    end
  end

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LOW_LIMIT_RST;
      high_limit_q <= HIGH_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_LOW_LIMIT:  low_limit_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: high_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // edge pairing, pulse width and distance scaling
  eprf_dist #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_q),
    .capture_i  (cap_q),
    .ctl_o      (ctl3),
    .raw_o      (raw3)
  );

  // moving average over the ring
  eprf_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl3),
    .raw_i  (raw3),
    .ctl_o  (ctl5),
    .raw_o  (raw5),
    .avg_o  (avg5)
  );

  // crossed limits simply never pass
  assign range_ok_d = (avg5 > low_limit_q) && (avg5 <= high_limit_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl5.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_raw_q      <= raw5;
      out_avg_q      <= avg5;
      out_done_q     <= ctl5.done;
      out_range_ok_q <= range_ok_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_range_ok_q, out_avg_q, out_raw_q});
  assign m_axis_tuser_o  = out_done_q;

endmodule

[hdl/eprf_checker.sv]
`timescale 1ns / 1ps

module eprf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [eprf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);
  import eprf_pkg::*;

  logic                  xfer;
  logic                  prev_done_q;
  logic [2*HEIGHT_W-1:0] prev_heights_q;

  assign xfer = m_axis_tvalid_o && m_axis_tready_i;

  // last result seen on the port, out of reset the first edge is a rising one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_done_q    <= 1'b1;
      prev_heights_q <= '0;
    end else if (xfer) begin
      prev_done_q    <= m_axis_tuser_o;
      prev_heights_q <= m_axis_tdata_o[2*HEIGHT_W-1:0];
    end
  end

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // edges alternate, so closed pulses alternate with rising edges
  a_done_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> m_axis_tuser_o != prev_done_q)
    else $error("measurement flag out of step with edge pairing");

  // a rising edge repeats the heights of the previous result
  a_rise_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !m_axis_tuser_o |-> m_axis_tdata_o[2*HEIGHT_W-1:0] == prev_heights_q)
    else $error("heights changed on a rising edge");

  // a height in range lies above the low limit, so it is never zero
  a_range_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && m_axis_tdata_o[2*HEIGHT_W] |-> m_axis_tdata_o[2*HEIGHT_W-1:HEIGHT_W] != '0)
    else $error("zero filtered height reported in range");

endmodule

bind echo_pulse_range_filter_unit eprf_checker u_checker (.*);
